[rtl/pffi_pkg.sv]
// Package for the PTP frame fault injector.
// Holds the rule word layout, cell and head control structs, codes and constants.
// No dependencies.
`default_nettype none
package pffi_pkg;

	localparam int RULES = 16;
	localparam int CNT_W = $clog2(RULES + 1);

	localparam logic [16:0] CNT_MAX   = 17'h1FFFF;
	localparam logic [31:0] LFSR_MASK = 32'h80200003;

	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_CLEAR = 3'd1;
	localparam logic [2:0] ACT_DEL   = 3'd2;
	localparam logic [2:0] ACT_FRAME = 3'd3;
	localparam logic [2:0] ACT_TS    = 3'd4;

	localparam logic [2:0] KIND_SKIP = 3'd0;
	localparam logic [2:0] KIND_DUP  = 3'd1;
	localparam logic [2:0] KIND_SEQ  = 3'd2;
	localparam logic [2:0] KIND_SEND = 3'd3;
	localparam logic [2:0] KIND_TS   = 3'd4;

	localparam logic [2:0] VERD_NONE = 3'd0;
	localparam logic [2:0] VERD_SKIP = 3'd1;
	localparam logic [2:0] VERD_DUP  = 3'd2;
	localparam logic [2:0] VERD_SEQ  = 3'd3;
	localparam logic [2:0] VERD_SEND = 3'd4;

	typedef struct packed {
		logic [3:0]  typ;
		logic [3:0]  port;
		logic [7:0]  dom;
		logic [2:0]  kind;
		logic [16:0] rate;
		logic [15:0] rep;
		logic [15:0] gap;
		logic [15:0] offs;
		logic [16:0] ic;
		logic [16:0] rc;
	} rule_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_ADD,
		OP_MARK,
		OP_COMPACT,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [3:0] del_type;
		rule_t      new_rule;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] typ;
		logic [3:0] port;
		logic [7:0] dom;
		logic       dom_any;
	} query_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [15:0] nseq;
		logic        drop;
		logic        done;
		logic [31:0] lfsr;
	} acc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/pffi_cell.sv]
// One rule cell of the chain: holds a rule and its valid bit.
// Depends on pffi_pkg.
`default_nettype none
module pffi_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pffi_pkg::cell_ctl_t  ctl,
	input  wire                  prev_v,
	input  wire                  hole_in,
	input  pffi_pkg::rule_t      nxt,
	input  wire                  nxt_v,
	output pffi_pkg::rule_t      cur,
	output logic                 cur_v,
	output logic                 hole_out
);
	import pffi_pkg::*;

	rule_t d_q, d_n;
	logic  v_q, v_n;

	always_comb begin
		d_n      = d_q;
		v_n      = v_q;
		hole_out = hole_in | ~v_q;
		case (ctl.op)
			OP_HOLD: ;
			OP_CLEAR: v_n = 1'b0;
			OP_ADD: begin
				if (prev_v && !v_q) begin
					v_n = 1'b1;
					d_n = ctl.new_rule;
				end
			end
			OP_MARK: begin
				if (v_q && d_q.typ == ctl.del_type) v_n = 1'b0;
			end
			OP_COMPACT: begin
				if (hole_out) begin
					v_n = nxt_v;
					d_n = nxt;
				end
			end
			OP_ROTATE: begin
				v_n = nxt_v;
				d_n = nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else v_q <= v_n;
	end

	always_ff @(posedge clk) begin
		d_q <= d_n;
	end

	assign cur   = d_q;
	assign cur_v = v_q;

endmodule
`default_nettype wire

[rtl/pffi_head.sv]
// Head unit: evaluates the rule at the front of the chain, advances counters and LFSR.
// Depends on pffi_pkg.
`default_nettype none
module pffi_head (
	input  pffi_pkg::rule_t  hd,
	input  wire              hd_v,
	input  pffi_pkg::query_t qry,
	input  pffi_pkg::acc_t   acc_in,
	output pffi_pkg::rule_t  upd,
	output pffi_pkg::acc_t   acc_out
);
	import pffi_pkg::*;

	logic        is_frame, is_ts, aware, handled, match, dom_eq, apply;
	logic        fire, hit, use_rate;
	logic [31:0] lfsr_n;
	logic [16:0] ic, rc;

	function automatic logic [16:0] sat_inc(input logic [16:0] v);
		return (v < CNT_MAX) ? v + 17'd1 : v;
	endfunction

	always_comb begin
		is_frame = qry.action == ACT_FRAME;
		is_ts    = qry.action == ACT_TS;
		aware    = qry.typ inside {4'd0, 4'd8, 4'd11, 4'd12};
		handled  = aware || (qry.typ inside {4'd2, 4'd3, 4'd10});
		match    = hd_v && hd.typ == qry.typ && hd.port == qry.port;
		dom_eq   = hd.dom == qry.dom;

		if (hd.rate[16]) begin
			lfsr_n = acc_in.lfsr;
			fire   = 1'b1;
		end else begin
			lfsr_n = {1'b0, acc_in.lfsr[31:1]} ^ (acc_in.lfsr[0] ? LFSR_MASK : 32'd0);
			fire   = lfsr_n[31:16] <= hd.rate[15:0];
		end

		ic       = hd.ic;
		rc       = hd.rc;
		use_rate = 1'b0;
		if (hd.rep == 16'd0) begin
			hit      = fire;
			use_rate = 1'b1;
		end else if (rc == 17'd0) begin
			rc       = 17'd1;
			hit      = fire;
			use_rate = 1'b1;
		end else if (hd.gap == 16'd0) begin
			hit = rc < {1'b0, hd.rep};
			rc  = sat_inc(rc);
		end else if (ic < {1'b0, hd.gap}) begin
			ic  = sat_inc(ic);
			hit = 1'b0;
		end else begin
			ic  = 17'd0;
			hit = rc < {1'b0, hd.rep};
			rc  = sat_inc(rc);
		end

		apply = (is_frame && handled && match && !(aware && !dom_eq) && hd.kind <= KIND_SEND)
			|| (is_ts && !acc_in.done && match && hd.kind == KIND_TS
				&& (qry.dom_any || dom_eq));

		upd     = hd;
		acc_out = acc_in;
		if (apply) begin
			upd.ic = ic;
			upd.rc = rc;
			if (use_rate) acc_out.lfsr = lfsr_n;
		end
		if (is_frame && handled && match) acc_out.verdict = VERD_NONE;
		if (is_frame && apply && hit) begin
			case (hd.kind)
				KIND_SKIP: acc_out.verdict = VERD_SKIP;
				KIND_DUP:  acc_out.verdict = VERD_DUP;
				KIND_SEND: acc_out.verdict = VERD_SEND;
				KIND_SEQ: begin
					acc_out.verdict = VERD_SEQ;
					if (hd.offs == 16'd0) acc_out.nseq = acc_in.nseq ^ 16'h00FF;
					else acc_out.nseq = acc_in.nseq + hd.offs;
				end
				default: ;
			endcase
		end
		if (is_ts && apply) begin
			acc_out.drop = hit;
			acc_out.done = 1'b1;
		end
	end

endmodule
`default_nettype wire

[rtl/ptp_frame_fault_injector_core.sv]
// Sequencing: add and clear act on all cells together, and unknown actions leave them as they are;
// delete by type marks matching cells and then compacts the chain; frame and timestamp checks rotate the cell chain.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: arst_n clears all cell valid bits, the sequencer and the output valid; LFSR loads 1.
// Top level of the fault injector; depends on pffi_pkg, pffi_cell, pffi_head.
`default_nettype none
module ptp_frame_fault_injector_core (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [31:0]  cfg_wdata,
	input  wire          s_tvalid,
	output logic         s_tready,
	// msg_type, port_index, domain, domain_any, fault_kind, fire_rate, repeat_limit,
	// gap_count, seq_offset, seq_id, zero pad
	input  wire  [103:0] s_tdata,
	// action
	input  wire  [2:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// verdict, new_seq_id, drop_timestamp, status, zero pad
	output logic [23:0]  m_tdata
);
	import pffi_pkg::*;

	state_t      state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic        last;
	query_t      qry_q;
	rule_t       nrule_q;
	acc_t        acc_q, acc_head;
	logic        status_q;
	cell_ctl_t   ctl;
	rule_t       cur [RULES];
	logic        cur_v [RULES];
	logic        hole [RULES];
	rule_t       head_upd, tail_d;
	logic        tail_v;
	logic        accept, load_out;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		case (qry_q.action)
			ACT_DEL:          last = cnt_q == CNT_W'(RULES);
			ACT_FRAME, ACT_TS: last = cnt_q == CNT_W'(RULES - 1);
			default:          last = 1'b1;
		endcase
	end

	always_comb begin
		state_n  = state_q;
		load_out = 1'b0;
		ctl.op       = OP_HOLD;
		ctl.del_type = qry_q.typ;
		ctl.new_rule = nrule_q;
		case (state_q)
			ST_IDLE: if (accept) state_n = ST_RUN;
			ST_RUN: begin
				case (qry_q.action)
					ACT_ADD:   if (!cur_v[RULES-1]) ctl.op = OP_ADD;
					ACT_CLEAR: ctl.op = OP_CLEAR;
					ACT_DEL:   ctl.op = (cnt_q == '0) ? OP_MARK : OP_COMPACT;
					ACT_FRAME, ACT_TS: ctl.op = OP_ROTATE;
					default:   ctl.op = OP_HOLD;
				endcase
				if (last) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					load_out = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign tail_d = (ctl.op == OP_ROTATE) ? head_upd : cur[0];
	assign tail_v = (ctl.op == OP_ROTATE) ? cur_v[0] : 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < RULES; gi++) begin : g_cell
			rule_t n_d;
			logic  n_v, p_v, h_in;
			if (gi == RULES - 1) begin : g_tail
				assign n_d = tail_d;
				assign n_v = tail_v;
			end else begin : g_mid
				assign n_d = cur[gi+1];
				assign n_v = cur_v[gi+1];
			end
			if (gi == 0) begin : g_first
				assign p_v  = 1'b1;
				assign h_in = 1'b0;
			end else begin : g_rest
				assign p_v  = cur_v[gi-1];
				assign h_in = hole[gi-1];
			end
			pffi_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.prev_v   (p_v),
				.hole_in  (h_in),
				.nxt      (n_d),
				.nxt_v    (n_v),
				.cur      (cur[gi]),
				.cur_v    (cur_v[gi]),
				.hole_out (hole[gi])
			);
		end
	endgenerate

	pffi_head u_head (
		.hd      (cur[0]),
		.hd_v    (cur_v[0]),
		.qry     (qry_q),
		.acc_in  (acc_q),
		.upd     (head_upd),
		.acc_out (acc_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_tvalid  <= 1'b0;
			acc_q     <= '{verdict: VERD_NONE, nseq: 16'd0, drop: 1'b0, done: 1'b0,
				lfsr: 32'd1};
			status_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				cnt_q        <= '0;
				status_q     <= 1'b0;
				acc_q.verdict <= VERD_NONE;
				acc_q.nseq   <= s_tdata[100:85];
				acc_q.drop   <= 1'b0;
				acc_q.done   <= 1'b0;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (qry_q.action == ACT_ADD && cur_v[RULES-1]) status_q <= 1'b1;
				if (ctl.op == OP_ROTATE) acc_q <= acc_head;
			end
			if (cfg_we) acc_q.lfsr <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
			if (load_out) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q.action  <= s_tuser;
			qry_q.typ     <= s_tdata[3:0];
			qry_q.port    <= s_tdata[7:4];
			qry_q.dom     <= s_tdata[15:8];
			qry_q.dom_any <= s_tdata[16];
			nrule_q.typ   <= s_tdata[3:0];
			nrule_q.port  <= s_tdata[7:4];
			nrule_q.dom   <= s_tdata[15:8];
			nrule_q.kind  <= s_tdata[19:17];
			nrule_q.rate  <= s_tdata[36:20];
			nrule_q.rep   <= s_tdata[52:37];
			nrule_q.gap   <= s_tdata[68:53];
			nrule_q.offs  <= s_tdata[84:69];
			nrule_q.ic    <= '0;
			nrule_q.rc    <= '0;
		end
		if (load_out) begin
			m_tdata[2:0]   <= (qry_q.action == ACT_FRAME) ? acc_q.verdict : VERD_NONE;
			m_tdata[18:3]  <= (qry_q.action == ACT_FRAME) ? acc_q.nseq : 16'd0;
			m_tdata[19]    <= (qry_q.action == ACT_TS) ? acc_q.drop : 1'b0;
			m_tdata[20]    <= status_q;
			m_tdata[23:21] <= 3'd0;
		end
	end

endmodule
`default_nettype wire

[rtl/pffi_checker.sv]
// Port-level checker for the fault injector core, with its bind.
// Depends on ptp_frame_fault_injector_core ports only.
`default_nettype none
module pffi_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [23:0]  m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("verdict out of range");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({m_tdata[2:0] != 3'd0, m_tdata[19], m_tdata[20]}) <= 1)
		else $error("verdict, drop and status from different actions");

endmodule

bind ptp_frame_fault_injector_core pffi_checker u_pffi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
